// File: src/mavg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average window package
// Shared constants, mode and register codes, controller/datapath interface.
// ----------------------------------------------------------------------------
package mavg_pkg;

    localparam int WINDOW_MAX_DEF    = 256;
    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int SUM_BITS          = 24;
    localparam int SIZE_BITS         = 9;
    localparam int OFFSET_BITS       = 9;
    localparam int MODE_BITS         = 2;
    localparam int CFG_INDEX_BITS    = 1;
    localparam int WINDOW_SIZE_RESET = 256;

    localparam logic [MODE_BITS-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_PEEK   = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_CLEAR  = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_FILL   = 2'd3;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_SIZE = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FILL_VALUE  = 1'd1;

    typedef struct packed {
        logic capture;
        logic mem_read;
        logic insert_wr;
        logic bulk;
        logic div_start;
        logic div_avg;
        logic idx_load;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [MODE_BITS-1:0] mode;
        logic                 div_done;
        logic                 out_free;
    } status_t;

endpackage

// File: src/mavg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial unsigned divider
// Restoring division, one quotient bit per cycle, done pulses once all DW quotient bits are in.
// ----------------------------------------------------------------------------
module mavg_div #(
    parameter int DW = 24,
    parameter int NW = 9
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [NW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient,
    output logic [NW-1:0] remainder
);

    localparam int CW = $clog2(DW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] quot_reg;
    logic [NW-1:0] rem_reg;
    logic [NW-1:0] dsr_reg;
    logic [NW:0]   trial;
    logic [NW:0]   diff;
    logic          ge;

    assign trial = {rem_reg, quot_reg[DW-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign ge    = (trial >= {1'b0, dsr_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(DW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dsr_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[DW-2:0], ge};
            rem_reg  <= ge ? diff[NW-1:0] : trial[NW-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

// File: src/mavg_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average datapath
// Sample ring memory, running sum, position, config registers, output stage.
// ----------------------------------------------------------------------------
module mavg_datapath #(
    parameter int WINDOW_MAX  = mavg_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         cfg_write,
    input  logic [mavg_pkg::CFG_INDEX_BITS-1:0]          cfg_index,
    input  logic [((SAMPLE_BITS > mavg_pkg::SIZE_BITS) ?
                   SAMPLE_BITS : mavg_pkg::SIZE_BITS)-1:0] cfg_data,
    input  logic [mavg_pkg::MODE_BITS-1:0]               mode,
    input  logic signed [SAMPLE_BITS-1:0]                sample,
    input  logic signed [mavg_pkg::OFFSET_BITS-1:0]      offset,
    input  mavg_pkg::cmd_t                               cmd,
    output mavg_pkg::status_t                            status,
    output logic                                         out_valid,
    input  logic                                         out_stall,
    output logic signed [SAMPLE_BITS-1:0]                average,
    output logic signed [SAMPLE_BITS-1:0]                peeked_value
);

    import mavg_pkg::*;

    localparam int POS_BITS = $clog2(WINDOW_MAX);
    localparam int NW       = $clog2(WINDOW_MAX + 1);
    localparam int VW       = ((POS_BITS > OFFSET_BITS) ? POS_BITS : OFFSET_BITS) + 2;
    localparam int XW       = ((SUM_BITS > SAMPLE_BITS) ? SUM_BITS : SAMPLE_BITS) + 2;
    localparam int PW       = (SUM_BITS > SAMPLE_BITS + NW + 1) ?
                              SUM_BITS : SAMPLE_BITS + NW + 1;
    localparam logic [XW-1:0] HI_MAG =
        {{(XW - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic [XW-1:0] LO_MAG = HI_MAG + XW'(1);
    localparam logic [SAMPLE_BITS-1:0] AVG_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] AVG_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    logic [SIZE_BITS-1:0]   size_reg;
    logic [SAMPLE_BITS-1:0] fill_reg;
    logic [MODE_BITS-1:0]   mode_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic [POS_BITS-1:0]    pos_reg;
    logic [POS_BITS-1:0]    addr_reg;
    logic [POS_BITS-1:0]    addr_next;
    logic [SUM_BITS-1:0]    sum_reg;
    logic [SUM_BITS-1:0]    sum_next;
    logic [SAMPLE_BITS-1:0] base_reg;
    logic [SAMPLE_BITS-1:0] base_next;
    logic [WINDOW_MAX-1:0]  valid_reg;
    logic [SAMPLE_BITS-1:0] mem [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic                   rd_valid_reg;
    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] average_reg;
    logic [SAMPLE_BITS-1:0] average_next;
    logic [SAMPLE_BITS-1:0] peeked_reg;
    logic [SAMPLE_BITS-1:0] peeked_next;

    logic [NW-1:0]          n;
    logic [NW-1:0]          pos_inc;
    logic [POS_BITS-1:0]    ins_addr;
    logic signed [VW-1:0]   v;
    logic [VW-1:0]          v_mag;
    logic [NW-1:0]          idx;
    logic [SUM_BITS-1:0]    sum_mag;
    logic [SUM_BITS-1:0]    dividend;
    logic [SUM_BITS-1:0]    quot;
    logic [NW-1:0]          rem;
    logic                   div_done;
    logic [SAMPLE_BITS-1:0] old;
    logic signed [XW-1:0]   sum_ins;
    logic signed [PW-1:0]   prod;
    logic [XW-1:0]          qx;
    logic [XW-1:0]          neg_q;

    // effective window size
    always_comb
    begin
        if (size_reg == '0)
            n = NW'(1);
        else if (32'(size_reg) > 32'(WINDOW_MAX))
            n = NW'(WINDOW_MAX);
        else
            n = NW'(size_reg);
    end

    assign pos_inc  = NW'(pos_reg) + NW'(1);
    assign ins_addr = (pos_inc >= n) ? '0 : POS_BITS'(pos_inc);

    assign v     = VW'(signed'({1'b0, pos_reg})) + VW'(signed'(offset_reg));
    assign v_mag = v[VW-1] ? VW'(-v) : VW'(v);
    assign idx   = (v[VW-1] && (rem != '0)) ? (n - rem) : rem;

    assign sum_mag  = sum_reg[SUM_BITS-1] ? (SUM_BITS'(0) - sum_reg) : sum_reg;
    assign dividend = cmd.div_avg ? sum_mag : SUM_BITS'(v_mag);

    mavg_div #(
        .DW (SUM_BITS),
        .NW (NW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (dividend),
        .divisor   (n),
        .done      (div_done),
        .quotient  (quot),
        .remainder (rem)
    );

    assign old     = rd_valid_reg ? rd_data_reg : base_reg;
    assign sum_ins = XW'(signed'(sum_reg)) + XW'(signed'(sample_reg)) - XW'(signed'(old));
    assign prod    = PW'(signed'(fill_reg)) * PW'(signed'({1'b0, n}));

    always_comb
    begin
        if (mode_reg == MODE_CLEAR)
        begin
            base_next = '0;
            sum_next  = '0;
        end
        else
        begin
            base_next = fill_reg;
            sum_next  = prod[SUM_BITS-1:0];
        end
    end

    always_comb
    begin
        if (cmd.capture)
            addr_next = ins_addr;
        else
            addr_next = POS_BITS'(idx);
    end

    // truncate toward zero, saturate to sample range
    assign qx    = XW'(quot);
    assign neg_q = XW'(0) - qx;

    always_comb
    begin
        if (sum_reg[SUM_BITS-1])
            average_next = (qx > LO_MAG) ? AVG_MIN : neg_q[SAMPLE_BITS-1:0];
        else
            average_next = (qx > HI_MAG) ? AVG_MAX : qx[SAMPLE_BITS-1:0];
        peeked_next = (mode_reg == MODE_PEEK) ? old : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= SIZE_BITS'(WINDOW_SIZE_RESET);
            fill_reg      <= '0;
            mode_reg      <= MODE_INSERT;
            pos_reg       <= '0;
            sum_reg       <= '0;
            base_reg      <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_WINDOW_SIZE: size_reg <= cfg_data[SIZE_BITS-1:0];
                    CFG_FILL_VALUE:  fill_reg <= cfg_data[SAMPLE_BITS-1:0];
                    default: ;
                endcase
            end
            if (cmd.capture)
                mode_reg <= mode;
            if (cmd.insert_wr)
            begin
                pos_reg             <= addr_reg;
                sum_reg             <= sum_ins[SUM_BITS-1:0];
                valid_reg[addr_reg] <= 1'b1;
            end
            if (cmd.bulk)
            begin
                pos_reg   <= '0;
                sum_reg   <= sum_next;
                base_reg  <= base_next;
                valid_reg <= '0;
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_reg <= sample;
            offset_reg <= offset;
        end
        if (cmd.capture || cmd.idx_load)
            addr_reg <= addr_next;
        if (cmd.out_load)
        begin
            average_reg <= average_next;
            peeked_reg  <= peeked_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.insert_wr)
            mem[addr_reg] <= sample_reg;
        if (cmd.mem_read)
        begin
            rd_data_reg  <= mem[addr_reg];
            rd_valid_reg <= valid_reg[addr_reg];
        end
    end

    assign status.mode     = mode_reg;
    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign average      = average_reg;
    assign peeked_value = peeked_reg;

endmodule

// File: src/mavg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average controller
// Sequences capture, memory access, sum update, division and output load.
// ----------------------------------------------------------------------------
module mavg_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  mavg_pkg::status_t status,
    output mavg_pkg::cmd_t    cmd
);

    import mavg_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DISPATCH  = 4'd1;
    localparam logic [3:0] S_READ      = 4'd2;
    localparam logic [3:0] S_UPDATE    = 4'd3;
    localparam logic [3:0] S_IDX_START = 4'd4;
    localparam logic [3:0] S_IDX_WAIT  = 4'd5;
    localparam logic [3:0] S_BULK      = 4'd6;
    localparam logic [3:0] S_AVG_START = 4'd7;
    localparam logic [3:0] S_AVG_WAIT  = 4'd8;
    localparam logic [3:0] S_OUT       = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (status.mode)
                    MODE_INSERT: state_next = S_READ;
                    MODE_PEEK:   state_next = S_IDX_START;
                    default:     state_next = S_BULK;
                endcase
            end
            S_READ:
            begin
                cmd.mem_read = 1'b1;
                state_next   = (status.mode == MODE_PEEK) ? S_AVG_START : S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.insert_wr = 1'b1;
                state_next    = S_AVG_START;
            end
            S_IDX_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_IDX_WAIT;
            end
            S_IDX_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.idx_load = 1'b1;
                    state_next   = S_READ;
                end
            end
            S_BULK:
            begin
                cmd.bulk   = 1'b1;
                state_next = S_AVG_START;
            end
            S_AVG_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_avg   = 1'b1;
                state_next    = S_AVG_WAIT;
            end
            S_AVG_WAIT:
            begin
                cmd.div_avg = 1'b1;
                if (status.div_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: src/moving_average_window_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average window unit
// Running-sum moving average over a ring of signed samples.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry mode, sample and offset. Output
// channel: out_valid / out_stall carry average and peeked_value. Every item
// gives exactly one result. Window size and fill value are written through
// cfg_write / cfg_index / cfg_data; the user must do this only while no
// item is in flight, since the block does not enforce it. Peek takes the
// longest. One item is worked on at a time: the next is accepted only
// after the previous result is loaded into the output register. The time
// is set mostly by the serial divider, which produces one quotient bit per
// cycle over the 24-bit sum: once for the average, and once more on peek
// to reduce the position plus offset modulo the window size.
// Reset clears the sum, the position and the entry valid bits, so every
// entry reads as zero; no clearing pass is needed. Window size resets to
// 256 and fill value to 0. A finished result waits in the output register
// while out_stall is high; the next item is accepted meanwhile and its
// result is held back until the register frees.
// ----------------------------------------------------------------------------
module moving_average_window_unit #(
    parameter int WINDOW_MAX  = mavg_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         cfg_write,
    input  logic [mavg_pkg::CFG_INDEX_BITS-1:0]          cfg_index,
    input  logic [((SAMPLE_BITS > mavg_pkg::SIZE_BITS) ?
                   SAMPLE_BITS : mavg_pkg::SIZE_BITS)-1:0] cfg_data,
    input  logic                                         in_valid,
    output logic                                         in_stall,
    input  logic [mavg_pkg::MODE_BITS-1:0]               mode,
    input  logic signed [SAMPLE_BITS-1:0]                sample,
    input  logic signed [mavg_pkg::OFFSET_BITS-1:0]      offset,
    output logic                                         out_valid,
    input  logic                                         out_stall,
    output logic signed [SAMPLE_BITS-1:0]                average,
    output logic signed [SAMPLE_BITS-1:0]                peeked_value
);

    import mavg_pkg::*;

    cmd_t    cmd;
    status_t status;

    mavg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    mavg_datapath #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mode         (mode),
        .sample       (sample),
        .offset       (offset),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .average      (average),
        .peeked_value (peeked_value)
    );

endmodule

// File: src/mavg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average port checker
// Port-level checks on handshake behavior and item sequencing.
// ----------------------------------------------------------------------------
module mavg_checker #(
    parameter int SAMPLE_BITS = mavg_pkg::SAMPLE_BITS_DEF
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic [SAMPLE_BITS-1:0] average,
    input logic [SAMPLE_BITS-1:0] peeked_value
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(average) && $stable(peeked_value))
        else $error("stalled result changed");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("item accepted while previous item in flight");

    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared with no item in flight");

endmodule

bind moving_average_window_unit mavg_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_mavg_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .average      (average),
    .peeked_value (peeked_value)
);
